/* src/mandelbrot_escape_time_assert.svh */
//------------------------------------------------------------------------------
// Mandelbrot escape time - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
//------------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MBE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mbe_pkg.sv */
//------------------------------------------------------------------------------
// Mandelbrot escape time - package
// Widths, fixed-point constants, payload types and controller types.
//------------------------------------------------------------------------------
package mbe_pkg;

    localparam int COORD_BITS    = 10;
    localparam int FRACTION_BITS = 28;

    localparam int QW      = FRACTION_BITS + 4;       // signed Q4.F value
    localparam int PW      = 2 * QW - FRACTION_BITS;  // product magnitude
    localparam int SW      = PW + 2;                  // update sums
    localparam int DW      = COORD_BITS + 1;          // |coord - origin|
    localparam int NW      = DW + FRACTION_BITS;      // scaled quotient
    localparam int COUNT_W = 16;
    localparam int SHADE_W = 8;

    localparam int ORIGIN_OFFSET = 400;
    localparam int SCALE_DIVISOR = 200;

    // Scale by a rounded-up reciprocal; exact for every magnitude below 2^DW
    // because 2^RECIP_SHIFT exceeds 2^DW * SCALE_DIVISOR.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = FRACTION_BITS + RECIP_SHIFT - $clog2(SCALE_DIVISOR) + 1;
    localparam int SCALE_W     = DW + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_Q =
        RECIP_W'(((64'd1 << (FRACTION_BITS + RECIP_SHIFT)) + 64'(SCALE_DIVISOR - 1))
                 / 64'(SCALE_DIVISOR));

    localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};
    localparam logic [NW-1:0] POS_LIMIT = {{(NW-QW+1){1'b0}}, {(QW-1){1'b1}}};
    localparam logic [NW-1:0] NEG_LIMIT = {{(NW-QW){1'b0}}, 1'b1, {(QW-1){1'b0}}};
    localparam logic [QW-1:0] TWO_Q     = QW'(64'd2 << FRACTION_BITS);
    localparam logic [PW:0]   FOUR_Q    = (PW+1)'(64'd4 << FRACTION_BITS);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0]  ADDR_MAX_ITERATIONS = '0;
    localparam logic [COUNT_W-1:0]  MAX_ITER_RESET      = 16'd256;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_column;
        logic [COORD_BITS-1:0] pixel_row;
    } pixel_t;

    typedef struct packed {
        logic [COUNT_W-1:0] iteration_count;
        logic [SHADE_W-1:0] shade_index;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CVT,
        ST_MUL,
        ST_UPD,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic c_load;
        logic mul;
        logic update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic stop;
    } status_t;

endpackage

/* src/mbe_regs.sv */
//------------------------------------------------------------------------------
// Mandelbrot escape time - configuration registers
// APB-style register file holding the per-pixel iteration limit.
//------------------------------------------------------------------------------
module mbe_regs
    import mbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [COUNT_W-1:0] max_iterations
);

    logic [COUNT_W-1:0] max_iter_reg;
    logic [COUNT_W-1:0] max_iter_next;
    logic               hit_max;

    assign hit_max = (paddr[PADDR_W-1:2] == ADDR_MAX_ITERATIONS);
    assign pready  = 1'b1;

    always_comb
    begin
        max_iter_next = max_iter_reg;
        if (psel && penable && pwrite && hit_max)
        begin
            max_iter_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RESET;
        end
        else
        begin
            max_iter_reg <= max_iter_next;
        end
    end

    assign prdata         = hit_max ? PDATA_W'(max_iter_reg) : '0;
    assign max_iterations = max_iter_reg;

endmodule

/* src/mbe_dpath.sv */
//------------------------------------------------------------------------------
// Mandelbrot escape time - datapath
// Reciprocal coordinate scaling, squaring unit, z update, counter, result register.
//------------------------------------------------------------------------------
`include "mandelbrot_escape_time_assert.svh"

module mbe_dpath
    import mbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  pixel_t             pixel,
    input  logic [COUNT_W-1:0] max_iterations,
    output result_t            result
);

    logic [COUNT_W-1:0]     k_reg;
    logic [COUNT_W-1:0]     k_next;

    logic                   sign_re_reg, sign_im_reg;
    logic [DW-1:0]          mag_re_reg, mag_im_reg;
    logic signed [QW-1:0]   cr_reg, ci_reg;
    logic signed [QW-1:0]   zr_reg, zi_reg;
    logic [PW-1:0]          rr_reg, ii_reg, ri_reg;
    logic                   ri_neg_reg;
    result_t                result_reg;

    logic [DW:0]            diff_re, diff_im;
    logic [DW:0]            abs_re, abs_im;
    logic [SCALE_W-1:0]     scale_re, scale_im;
    logic [NW-1:0]          quot_re, quot_im;

    logic [QW-1:0]          mag_r, mag_i;
    logic [2*QW-1:0]        prod_rr, prod_ii, prod_ri;
    logic signed [SW-1:0]   re_sum, im_sum, ri2;
    logic [PW:0]            sq_sum;
    logic                   esc;

    function automatic logic [DW:0] coord_diff(input logic [COORD_BITS-1:0] c);
        return {{(DW+1-COORD_BITS){1'b0}}, c} - (DW+1)'(ORIGIN_OFFSET);
    endfunction

    function automatic logic [QW-1:0] q_mag(input logic signed [QW-1:0] v);
        return v[QW-1] ? (~v + 1'b1) : v;
    endfunction

    // Apply the sign to the quotient and clamp it to the Q4 range.
    function automatic logic signed [QW-1:0] quot_to_q(input logic neg,
                                                       input logic [NW-1:0] q);
        logic signed [QW-1:0] r;
        if (!neg)
        begin
            r = (q > POS_LIMIT) ? Q_MAX : q[QW-1:0];
        end
        else
        begin
            r = (q > NEG_LIMIT) ? Q_MIN : -q[QW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [QW-1:0] sat_q(input logic signed [SW-1:0] v);
        logic signed [QW-1:0] r;
        if (v > SW'(Q_MAX))
        begin
            r = Q_MAX;
        end
        else if (v < SW'(Q_MIN))
        begin
            r = Q_MIN;
        end
        else
        begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    // Coordinate offset and magnitude
    assign diff_re = coord_diff(pixel.pixel_column);
    assign diff_im = coord_diff(pixel.pixel_row);
    assign abs_re  = diff_re[DW] ? -diff_re : diff_re;
    assign abs_im  = diff_im[DW] ? -diff_im : diff_im;

    // Magnitude * 2^F / scale, truncated, by reciprocal multiply
    assign scale_re = {{RECIP_W{1'b0}}, mag_re_reg} * {{DW{1'b0}}, RECIP_Q};
    assign scale_im = {{RECIP_W{1'b0}}, mag_im_reg} * {{DW{1'b0}}, RECIP_Q};
    assign quot_re  = NW'(scale_re[SCALE_W-1:RECIP_SHIFT]);
    assign quot_im  = NW'(scale_im[SCALE_W-1:RECIP_SHIFT]);

    // Squaring unit
    assign mag_r   = q_mag(zr_reg);
    assign mag_i   = q_mag(zi_reg);
    assign prod_rr = mag_r * mag_r;
    assign prod_ii = mag_i * mag_i;
    assign prod_ri = mag_r * mag_i;

    // Update and escape test on the registered products
    always_comb
    begin
        ri2    = $signed({1'b0, ri_reg, 1'b0});
        re_sum = $signed({2'b00, rr_reg}) - $signed({2'b00, ii_reg}) + SW'(cr_reg);
        im_sum = (ri_neg_reg ? -ri2 : ri2) + SW'(ci_reg);
        sq_sum = {1'b0, rr_reg} + {1'b0, ii_reg};
        esc    = (mag_r >= TWO_Q) || (mag_i >= TWO_Q) || (sq_sum >= FOUR_Q);
    end

    assign status.stop = (k_reg != '0) && (esc || (k_reg >= max_iterations));

    always_comb
    begin
        k_next = k_reg;
        if (cmd.load)
        begin
            k_next = '0;
        end
        else if (cmd.update)
        begin
            k_next = k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else
        begin
            k_reg <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sign_re_reg <= diff_re[DW];
            sign_im_reg <= diff_im[DW];
            mag_re_reg  <= abs_re[DW-1:0];
            mag_im_reg  <= abs_im[DW-1:0];
        end

        if (cmd.c_load)
        begin
            cr_reg <= quot_to_q(sign_re_reg, quot_re);
            ci_reg <= quot_to_q(sign_im_reg, quot_im);
            zr_reg <= '0;
            zi_reg <= '0;
        end
        else if (cmd.update)
        begin
            zr_reg <= sat_q(re_sum);
            zi_reg <= sat_q(im_sum);
        end

        if (cmd.mul)
        begin
            rr_reg     <= prod_rr[2*QW-1:FRACTION_BITS];
            ii_reg     <= prod_ii[2*QW-1:FRACTION_BITS];
            ri_reg     <= prod_ri[2*QW-1:FRACTION_BITS];
            ri_neg_reg <= zr_reg[QW-1] ^ zi_reg[QW-1];
        end

        if (cmd.out_load)
        begin
            result_reg.iteration_count <= k_reg;
            result_reg.shade_index     <= k_reg[SHADE_W-1:0];
        end
    end

    assign result = result_reg;

    `MBE_ASSERT_NOW(a_count_below_limit, cmd.update && (k_reg != '0), k_reg < max_iterations, "update past the iteration limit")
    `MBE_ASSERT_NOW(a_count_nonzero, cmd.out_load, k_reg != '0, "result taken with zero count")
    `MBE_ASSERT_NEXT(a_z_cleared, cmd.c_load, (zr_reg == '0) && (zi_reg == '0), "z not cleared at start")

endmodule

/* src/mbe_ctrl.sv */
//------------------------------------------------------------------------------
// Mandelbrot escape time - controller
// Sequences scaling, iteration and result hand-off; owns the output valid.
//------------------------------------------------------------------------------
`include "mandelbrot_escape_time_assert.svh"

module mbe_ctrl
    import mbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pixel_valid,
    output logic    pixel_ready,
    output logic    result_valid,
    input  logic    result_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        pixel_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pixel_ready = 1'b1;
                if (pixel_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CVT;
                end
            end
            ST_CVT:
            begin
                cmd.c_load = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (status.stop)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.update = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (!result_valid_reg || result_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    `MBE_ASSERT_NEXT(a_accept_starts_scale, pixel_valid && pixel_ready, state_reg == ST_CVT, "accepted request did not start scaling")
    `MBE_ASSERT_NEXT(a_result_held, result_valid_reg && !result_ready, result_valid_reg, "pending result dropped")
    `MBE_ASSERT_NOW(a_no_overwrite, cmd.out_load, !result_valid_reg || result_ready, "result register overwritten")

endmodule

/* src/mandelbrot_escape_time.sv */
//------------------------------------------------------------------------------
// Mandelbrot escape time - top level
// Maps a pixel to c, iterates z = z*z + c in Q4.28 and returns the count.
//------------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Payload
//  pixel     in         pixel_valid / pixel_ready    pixel_t (column, row)
//  result    out        result_valid / result_ready  result_t (count, shade)
//  config    in         psel/penable/pwrite, pready  max_iterations at 0x0
//
//  For a count of n, an item is accepted, its coordinates are scaled by
//  reciprocal, it makes n + 1 passes (squaring unit, then add and escape
//  test), and the result register is loaded.
//  Reset is asynchronous, active low; the limit returns to 256.
//  A finished result waits in the output register; a new pixel is taken
//  meanwhile, and only its own hand-off stalls if the register is still full.
//------------------------------------------------------------------------------
module mandelbrot_escape_time
    import mbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               pixel_valid,
    output logic               pixel_ready,
    input  pixel_t             pixel,
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result
);

    logic [COUNT_W-1:0] max_iterations;
    cmd_t               cmd;
    status_t            status;

    mbe_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .max_iterations (max_iterations)
    );

    mbe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    mbe_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .pixel          (pixel),
        .max_iterations (max_iterations),
        .result         (result)
    );

endmodule
